// File: hdl/vsot_pkg.sv
// ----------------------------------------------------------------------------
// vsot_pkg: shared types and constants of the voxel store
// volume geometry, derived widths, opcodes, sequencer states and memory words
// ----------------------------------------------------------------------------
`default_nettype none

package vsot_pkg;

  // volume geometry
  localparam int VOL_WIDTH  = 64;
  localparam int VOL_HEIGHT = 64;
  localparam int VOL_DEPTH  = 64;

  localparam int CELL_SHIFT = 3;
  localparam int CELLS_X    = (VOL_WIDTH + 7) / 8;
  localparam int CELLS_Y    = (VOL_HEIGHT + 7) / 8;
  localparam int CELLS_Z    = (VOL_DEPTH + 7) / 8;
  localparam int CELL_COUNT  = CELLS_X * CELLS_Y * CELLS_Z;
  localparam int VOXEL_COUNT = VOL_WIDTH * VOL_HEIGHT * VOL_DEPTH;

  // address and position widths
  localparam int VOX_AW  = (VOXEL_COUNT > 1) ? $clog2(VOXEL_COUNT) : 1;
  localparam int CELL_AW = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int X_W     = (VOL_WIDTH > 1) ? $clog2(VOL_WIDTH) : 1;
  localparam int Y_W     = (VOL_HEIGHT > 1) ? $clog2(VOL_HEIGHT) : 1;
  localparam int Z_W     = (VOL_DEPTH > 1) ? $clog2(VOL_DEPTH) : 1;
  localparam int RX_W    = $clog2(VOL_WIDTH + 1);
  localparam int RY_W    = $clog2(VOL_HEIGHT + 1);

  // field widths
  localparam int OP_W       = 2;
  localparam int CRD_W      = 16;
  localparam int VAL_W      = 8;
  localparam int SOLID_W    = 19;
  localparam int RECT_OUT_W = 7;
  localparam int CNT_W      = 10;
  localparam logic [CNT_W-1:0] COUNT_MAX = 10'd1023;

  // shared adder width
  localparam int ALU_W = (VOX_AW > SOLID_W) ? VOX_AW : SOLID_W;

  // register port
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;
  localparam int REG_IDX_W = APB_AW - 2;
  localparam logic [REG_IDX_W-1:0] REG_TRACKING = '0;

  typedef enum logic [OP_W-1:0] {
    OP_READ,
    OP_WRITE,
    OP_TAKE_RECT,
    OP_TAKE_FLAG
  } opcode_e;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  typedef logic [ALU_W-1:0] alu_word_t;

  typedef struct packed {
    alu_op_e   op;
    alu_word_t a;
    alu_word_t b;
  } alu_req_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADR_VT,
    ST_ADR_CT,
    ST_ADR_VI,
    ST_ADR_CI,
    ST_READ,
    ST_EVAL,
    ST_CNT,
    ST_TOT,
    ST_WRBK,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [RX_W-1:0] lo_x;
    logic [RY_W-1:0] lo_y;
    logic [RX_W-1:0] hi_x;
    logic [RY_W-1:0] hi_y;
  } rect_t;

  localparam rect_t RECT_EMPTY = '{
    lo_x: RX_W'(VOL_WIDTH),
    lo_y: RY_W'(VOL_HEIGHT),
    hi_x: '0,
    hi_y: '0
  };

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic             occ;
    logic             chg;
  } cell_t;

  typedef struct packed {
    logic              en;
    logic [VOX_AW-1:0] addr;
    logic [VAL_W-1:0]  data;
  } vox_wr_t;

  typedef struct packed {
    logic               en;
    logic [CELL_AW-1:0] addr;
    cell_t              data;
  } cell_wr_t;

  typedef struct packed {
    logic           en;
    logic [Z_W-1:0] addr;
    rect_t          data;
  } rect_wr_t;

  typedef struct packed {
    logic [VOX_AW-1:0]  vox;
    logic [CELL_AW-1:0] coarse;
    logic [Z_W-1:0]     rect;
  } mem_rd_addr_t;

  typedef struct packed {
    logic [VAL_W-1:0] vox;
    cell_t            coarse;
    rect_t            rect;
  } mem_rd_data_t;

endpackage

`default_nettype wire

// File: hdl/vsot_if.sv
// ----------------------------------------------------------------------------
// vsot_if: request and result channels of the voxel store
// valid/ready handshake, a word moves when both are high at a clock edge
// ----------------------------------------------------------------------------
`default_nettype none

interface vsot_in_if import vsot_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         opcode;
  logic signed [CRD_W-1:0] coord_x;
  logic signed [CRD_W-1:0] coord_y;
  logic signed [CRD_W-1:0] coord_z;
  logic [VAL_W-1:0]        new_value;

  modport source (output valid, opcode, coord_x, coord_y, coord_z, new_value,
                  input ready);
  modport sink   (input valid, opcode, coord_x, coord_y, coord_z, new_value,
                  output ready);
endinterface

interface vsot_out_if import vsot_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  in_range;
  logic [VAL_W-1:0]      voxel_value;
  logic [SOLID_W-1:0]    solid_total;
  logic                  cell_occupied;
  logic                  cell_changed;
  logic [RECT_OUT_W-1:0] rect_min_x;
  logic [RECT_OUT_W-1:0] rect_min_y;
  logic [RECT_OUT_W-1:0] rect_max_x;
  logic [RECT_OUT_W-1:0] rect_max_y;

  modport source (output valid, in_range, voxel_value, solid_total, cell_occupied,
                  cell_changed, rect_min_x, rect_min_y, rect_max_x, rect_max_y,
                  input ready);
  modport sink   (input valid, in_range, voxel_value, solid_total, cell_occupied,
                  cell_changed, rect_min_x, rect_min_y, rect_max_x, rect_max_y,
                  output ready);
endinterface

`default_nettype wire

// File: hdl/vsot_ram.sv
// ----------------------------------------------------------------------------
// vsot_ram: generic simple dual-port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module vsot_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                          wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: hdl/vsot_alu.sv
// ----------------------------------------------------------------------------
// vsot_alu: shared add/subtract unit
// one operation per cycle, used for address steps and count updates
// ----------------------------------------------------------------------------
`default_nettype none

module vsot_alu import vsot_pkg::*; (
  input  wire alu_req_t  req_i,
  output alu_word_t      sum_o
);

  always_comb begin
    case (req_i.op)
      ALU_ADD: sum_o = req_i.a + req_i.b;
      ALU_SUB: sum_o = req_i.a - req_i.b;
      default: sum_o = req_i.a;
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/vsot_seq.sv
// ----------------------------------------------------------------------------
// vsot_seq: sequencer and datapath registers of the voxel store
// walks one word through address, read, count update and write back steps
// ----------------------------------------------------------------------------
`default_nettype none

module vsot_seq import vsot_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  vsot_in_if.sink           in_i,
  vsot_out_if.source        out_o,
  input  wire logic         tracking_i,
  output alu_req_t          alu_req_o,
  input  wire alu_word_t    alu_sum_i,
  output vox_wr_t           vox_wr_o,
  output cell_wr_t          cell_wr_o,
  output rect_wr_t          rect_wr_o,
  output mem_rd_addr_t      rd_addr_o,
  input  wire mem_rd_data_t rd_data_i
);

  state_e state_q, state_d;
  logic [VOX_AW-1:0]  clr_q, clr_d;
  logic [SOLID_W-1:0] total_q, total_d;
  logic               out_valid_q, out_valid_d;

  opcode_e            op_q;
  logic [X_W-1:0]     x_q;
  logic [Y_W-1:0]     y_q;
  logic [Z_W-1:0]     z_q;
  logic [VAL_W-1:0]   val_q;
  logic               ok_q, zok_q;
  alu_word_t          vt_q, ct_q;
  logic [VOX_AW-1:0]  vi_q;
  logic [CELL_AW-1:0] ci_q;
  logic [VAL_W-1:0]   vox_q;
  cell_t              cell_q;
  rect_t              rect_q;

  logic                  res_in_range_q;
  logic [VAL_W-1:0]      res_value_q;
  logic [SOLID_W-1:0]    res_total_q;
  logic                  res_occ_q;
  logic                  res_chg_q;
  logic [RECT_OUT_W-1:0] res_min_x_q, res_min_y_q, res_max_x_q, res_max_y_q;

  logic             in_ready;
  logic             out_load;
  logic             xok, yok, zok;
  logic [CNT_W-1:0] cnt_new;
  logic             flip_cell;
  rect_t            rect_grown;
  logic [RX_W-1:0]  x_ext, x_next;
  logic [RY_W-1:0]  y_ext, y_next;
  logic             show_rect, show_vox;
  logic             solid_flip;

  // range checks on the incoming word
  assign xok = !in_i.coord_x[CRD_W-1] &&
               (in_i.coord_x[CRD_W-2:0] < (CRD_W-1)'(VOL_WIDTH));
  assign yok = !in_i.coord_y[CRD_W-1] &&
               (in_i.coord_y[CRD_W-2:0] < (CRD_W-1)'(VOL_HEIGHT));
  assign zok = !in_i.coord_z[CRD_W-1] &&
               (in_i.coord_z[CRD_W-2:0] < (CRD_W-1)'(VOL_DEPTH));

  // saturating cell count, sum comes from the shared unit
  always_comb begin
    cnt_new = cell_q.cnt;
    if (val_q != '0) begin
      if (cell_q.cnt != COUNT_MAX) begin
        cnt_new = alu_sum_i[CNT_W-1:0];
      end
    end else if (cell_q.cnt != '0) begin
      cnt_new = alu_sum_i[CNT_W-1:0];
    end
  end
  assign flip_cell = (cell_q.cnt == '0) != (cnt_new == '0);

  // dirty rectangle grown to cover the voxel
  assign x_ext  = RX_W'(x_q);
  assign y_ext  = RY_W'(y_q);
  assign x_next = x_ext + RX_W'(1);
  assign y_next = y_ext + RY_W'(1);
  always_comb begin
    rect_grown = rect_q;
    if (x_ext < rect_q.lo_x) rect_grown.lo_x = x_ext;
    if (y_ext < rect_q.lo_y) rect_grown.lo_y = y_ext;
    if (x_next > rect_q.hi_x) rect_grown.hi_x = x_next;
    if (y_next > rect_q.hi_y) rect_grown.hi_y = y_next;
  end

  assign solid_flip = (rd_data_i.vox == '0) != (val_q == '0);
  assign show_rect  = (op_q == OP_TAKE_RECT) ? zok_q : ok_q;
  assign show_vox   = ok_q && (op_q != OP_TAKE_RECT);

  assign rd_addr_o = '{vox: vi_q, coarse: ci_q, rect: z_q};

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    total_d     = total_q;
    in_ready    = 1'b0;
    out_load    = 1'b0;
    alu_req_o   = '{op: ALU_ADD, a: '0, b: '0};
    vox_wr_o    = '0;
    cell_wr_o   = '0;
    rect_wr_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        vox_wr_o  = '{en: 1'b1, addr: clr_q, data: '0};
        cell_wr_o = '{en: ({1'b0, clr_q} < (VOX_AW+1)'(CELL_COUNT)),
                      addr: clr_q[CELL_AW-1:0], data: '0};
        rect_wr_o = '{en: ({1'b0, clr_q} < (VOX_AW+1)'(VOL_DEPTH)),
                      addr: clr_q[Z_W-1:0], data: RECT_EMPTY};
        clr_d = clr_q + VOX_AW'(1);
        if (clr_q == VOX_AW'(VOXEL_COUNT - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_i.valid) begin
          if (opcode_e'(in_i.opcode) != OP_TAKE_RECT && xok && yok && zok) begin
            state_d = ST_ADR_VT;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_ADR_VT: begin
        alu_req_o.a = alu_word_t'(y_q);
        alu_req_o.b = alu_word_t'(alu_word_t'(z_q) * alu_word_t'(VOL_HEIGHT));
        state_d = ST_ADR_CT;
      end
      ST_ADR_CT: begin
        alu_req_o.a = alu_word_t'(y_q) >> CELL_SHIFT;
        alu_req_o.b = alu_word_t'((alu_word_t'(z_q) >> CELL_SHIFT) * alu_word_t'(CELLS_Y));
        state_d = ST_ADR_VI;
      end
      ST_ADR_VI: begin
        alu_req_o.a = alu_word_t'(x_q);
        alu_req_o.b = alu_word_t'(vt_q * alu_word_t'(VOL_WIDTH));
        state_d = ST_ADR_CI;
      end
      ST_ADR_CI: begin
        alu_req_o.a = alu_word_t'(x_q) >> CELL_SHIFT;
        alu_req_o.b = alu_word_t'(ct_q * alu_word_t'(CELLS_X));
        state_d = ST_READ;
      end
      ST_READ: begin
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (op_q == OP_WRITE && ok_q && rd_data_i.vox != val_q) begin
          state_d = solid_flip ? ST_CNT : ST_WRBK;
        end else begin
          state_d = ST_RESP;
        end
      end
      ST_CNT: begin
        alu_req_o.op = (val_q != '0) ? ALU_ADD : ALU_SUB;
        alu_req_o.a  = alu_word_t'(cell_q.cnt);
        alu_req_o.b  = alu_word_t'(1);
        state_d = ST_TOT;
      end
      ST_TOT: begin
        alu_req_o.op = (val_q != '0) ? ALU_ADD : ALU_SUB;
        alu_req_o.a  = alu_word_t'(total_q);
        alu_req_o.b  = alu_word_t'(1);
        if (val_q != '0 || total_q != '0) begin
          total_d = alu_sum_i[SOLID_W-1:0];
        end
        state_d = ST_WRBK;
      end
      ST_WRBK: begin
        vox_wr_o  = '{en: 1'b1, addr: vi_q, data: val_q};
        cell_wr_o = '{en: 1'b1, addr: ci_q, data: cell_q};
        rect_wr_o = '{en: tracking_i, addr: z_q, data: rect_grown};
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
          // read-and-clear side effects happen once, as the result is loaded
          if (op_q == OP_TAKE_RECT && zok_q) begin
            rect_wr_o = '{en: 1'b1, addr: z_q, data: RECT_EMPTY};
          end
          if (op_q == OP_TAKE_FLAG && ok_q) begin
            cell_wr_o = '{en: 1'b1, addr: ci_q,
                          data: '{cnt: cell_q.cnt, occ: cell_q.occ, chg: 1'b0}};
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          op_q  <= opcode_e'(in_i.opcode);
          x_q   <= in_i.coord_x[X_W-1:0];
          y_q   <= in_i.coord_y[Y_W-1:0];
          z_q   <= in_i.coord_z[Z_W-1:0];
          val_q <= in_i.new_value;
          ok_q  <= xok && yok && zok;
          zok_q <= zok;
        end
      end
      ST_ADR_VT: vt_q <= alu_sum_i;
      ST_ADR_CT: ct_q <= alu_sum_i;
      ST_ADR_VI: vi_q <= alu_sum_i[VOX_AW-1:0];
      ST_ADR_CI: ci_q <= alu_sum_i[CELL_AW-1:0];
      ST_EVAL: begin
        vox_q  <= rd_data_i.vox;
        cell_q <= rd_data_i.coarse;
        rect_q <= rd_data_i.rect;
      end
      ST_CNT: begin
        cell_q.cnt <= cnt_new;
        if (flip_cell) begin
          cell_q.occ <= (cnt_new != '0);
          cell_q.chg <= 1'b1;
        end
      end
      ST_WRBK: begin
        vox_q <= val_q;
        if (tracking_i) begin
          rect_q <= rect_grown;
        end
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_in_range_q <= show_rect;
      res_value_q    <= show_vox ? vox_q : '0;
      res_occ_q      <= show_vox && cell_q.occ;
      res_chg_q      <= show_vox && cell_q.chg;
      res_total_q    <= total_q;
      res_min_x_q    <= show_rect ? RECT_OUT_W'(rect_q.lo_x) : RECT_OUT_W'(VOL_WIDTH);
      res_min_y_q    <= show_rect ? RECT_OUT_W'(rect_q.lo_y) : RECT_OUT_W'(VOL_HEIGHT);
      res_max_x_q    <= show_rect ? RECT_OUT_W'(rect_q.hi_x) : '0;
      res_max_y_q    <= show_rect ? RECT_OUT_W'(rect_q.hi_y) : '0;
    end
  end

  assign in_i.ready          = in_ready;
  assign out_o.valid         = out_valid_q;
  assign out_o.in_range      = res_in_range_q;
  assign out_o.voxel_value   = res_value_q;
  assign out_o.solid_total   = res_total_q;
  assign out_o.cell_occupied = res_occ_q;
  assign out_o.cell_changed  = res_chg_q;
  assign out_o.rect_min_x    = res_min_x_q;
  assign out_o.rect_min_y    = res_min_y_q;
  assign out_o.rect_max_x    = res_max_x_q;
  assign out_o.rect_max_y    = res_max_y_q;

endmodule

`default_nettype wire

// File: hdl/voxel_store_occupancy_tracker.sv
// ----------------------------------------------------------------------------
// voxel_store_occupancy_tracker: byte voxel volume with occupancy bookkeeping
// voxel, coarse cell and slice rectangle stores behind a small sequencer
// ----------------------------------------------------------------------------
// usage
// - in_i carries one request word (opcode, coordinates, new value); out_o
//   returns exactly one result word per request, in order
// - apb port holds tracking_enabled at byte address 0; write it only while
//   no request is in flight
// - one request at a time; in_i.ready is high only while the sequencer idles
// - a shared adder does the four address steps (slice row, cell row, voxel
//   index, cell index) and then the cell and total count updates, one step a
//   cycle; the stores have registered reads, which costs a wait state
// - read and take-cell-flag run the address steps, read wait and evaluate;
//   a value-changing write adds a write back, after the count updates if it
//   flips empty/solid; take-rectangle and out-of-range requests skip the
//   address steps; the next request is taken the cycle after a result loads
// - after reset the stores are swept to their empty values, one voxel per
//   cycle across all 262144 voxels; in_i.ready stays low meanwhile
// - a result waits in the output register when out_o.ready is low; a new
//   request is still accepted and works up to its result step, then holds
// ----------------------------------------------------------------------------
`default_nettype none

module voxel_store_occupancy_tracker import vsot_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  vsot_in_if.sink                in_i,
  vsot_out_if.source             out_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  logic         tracking_q;
  logic         cfg_write;
  alu_req_t     alu_req;
  alu_word_t    alu_sum;
  vox_wr_t      vox_wr;
  cell_wr_t     cell_wr;
  rect_wr_t     rect_wr;
  mem_rd_addr_t rd_addr;
  mem_rd_data_t rd_data;

  // register port: pready is always high, write lands in the access phase
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready &&
                     (paddr[APB_AW-1:2] == REG_TRACKING);
  assign prdata    = (paddr[APB_AW-1:2] == REG_TRACKING) ? APB_DW'(tracking_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tracking_q <= 1'b0;
    end else if (cfg_write) begin
      tracking_q <= pwdata[0];
    end
  end

  // shared arithmetic unit
  vsot_alu u_alu (
    .req_i (alu_req),
    .sum_o (alu_sum)
  );

  // sequencer
  vsot_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .out_o      (out_o),
    .tracking_i (tracking_q),
    .alu_req_o  (alu_req),
    .alu_sum_i  (alu_sum),
    .vox_wr_o   (vox_wr),
    .cell_wr_o  (cell_wr),
    .rect_wr_o  (rect_wr),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data)
  );

  // voxel bytes
  vsot_ram #(
    .WIDTH (VAL_W),
    .DEPTH (VOXEL_COUNT)
  ) u_vox_ram (
    .clk_i   (clk_i),
    .we_i    (vox_wr.en),
    .waddr_i (vox_wr.addr),
    .wdata_i (vox_wr.data),
    .raddr_i (rd_addr.vox),
    .rdata_o (rd_data.vox)
  );

  // per-cell solid count, occupancy bit and changed flag
  vsot_ram #(
    .WIDTH ($bits(cell_t)),
    .DEPTH (CELL_COUNT)
  ) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (cell_wr.en),
    .waddr_i (cell_wr.addr),
    .wdata_i (cell_wr.data),
    .raddr_i (rd_addr.coarse),
    .rdata_o (rd_data.coarse)
  );

  // per-slice dirty rectangles
  vsot_ram #(
    .WIDTH ($bits(rect_t)),
    .DEPTH (VOL_DEPTH)
  ) u_rect_ram (
    .clk_i   (clk_i),
    .we_i    (rect_wr.en),
    .waddr_i (rect_wr.addr),
    .wdata_i (rect_wr.data),
    .raddr_i (rd_addr.rect),
    .rdata_o (rd_data.rect)
  );

  // a request keeps the sequencer busy in the cycle after it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("sequencer took a second word right after the first");

  // no store is written while the sequencer waits for a word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> (!vox_wr.en && !cell_wr.en && !rect_wr.en))
    else $error("store written while idle");

  // a result is only loaded from a busy sequencer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(!in_i.ready))
    else $error("result loaded while idle");

endmodule

`default_nettype wire
